>>> sv/ccrs_pkg.sv
// Shared constants, control types and build-time point table for the spline evaluator.
package ccrs_pkg;

	localparam int N_POINTS_DEF        = 8;
	localparam int COORD_FRAC_BITS_DEF = 12;
	localparam int ROM_SLOTS           = 16;
	localparam int AXES                = 3;
	localparam int MILLI               = 1000;
	localparam int COEF_MARGIN         = 8;
	localparam int S_W                 = 16;
	localparam int OUT_W               = 16;
	localparam int OUT_MAX             = 32767;
	localparam int OUT_MIN             = -32768;

	localparam int COEF_A0 = 0;
	localparam int COEF_A1 = 1;
	localparam int COEF_A2 = 2;
	localparam int COEF_A3 = 3;

	localparam int ROM_MILLI [ROM_SLOTS][AXES] = '{
		'{3500, 800, 0}, '{2500, 1500, 2500}, '{0, 1800, 3500},
		'{-2500, 1200, 2500}, '{-3500, 500, 0}, '{-2500, -200, -2500},
		'{0, -500, -3500}, '{2500, 200, -2500},
		'{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0},
		'{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}
	};

	typedef struct packed {
		logic           vld;
		logic [S_W-1:0] s;
	} ccrs_ctl_t;

	function automatic longint ccrs_coord(int idx, int axis, int frac);
		longint v;
		longint mag;
		longint r;
		v   = longint'(ROM_MILLI[idx][axis]);
		mag = (v < 0) ? -v : v;
		r   = (mag * (longint'(1) << frac) + 500) / MILLI;
		return (v < 0) ? -r : r;
	endfunction

	function automatic longint ccrs_coef(int n, int frac, int seg, int axis, int which);
		int     im;
		int     i1;
		int     i2;
		longint pm;
		longint p0;
		longint p1;
		longint p2;
		longint r;
		im = (seg == 0) ? n - 1 : seg - 1;
		i1 = (seg + 1 >= n) ? seg + 1 - n : seg + 1;
		i2 = (seg + 2 >= n) ? seg + 2 - n : seg + 2;
		pm = ccrs_coord(im, axis, frac);
		p0 = ccrs_coord(seg, axis, frac);
		p1 = ccrs_coord(i1, axis, frac);
		p2 = ccrs_coord(i2, axis, frac);
		case (which)
			COEF_A0: r = 2 * p0;
			COEF_A1: r = p1 - pm;
			COEF_A2: r = 2 * pm - 5 * p0 + 4 * p1 - p2;
			default: r = -pm + 3 * p0 - 3 * p1 + p2;
		endcase
		return r;
	endfunction

	function automatic logic [OUT_W-1:0] ccrs_sat(longint v);
		logic [OUT_W-1:0] r;
		if (v > longint'(OUT_MAX)) begin
			r = OUT_W'(OUT_MAX);
		end else if (v < longint'(OUT_MIN)) begin
			r = OUT_W'(OUT_MIN);
		end else begin
			r = OUT_W'(v);
		end
		return r;
	endfunction

endpackage

>>> sv/ccrs_coef_lut.sv
// Segment split of the phase and per-segment polynomial coefficient lookup.
module ccrs_coef_lut import ccrs_pkg::*; #(
	parameter int N_POINTS        = N_POINTS_DEF,
	parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
	parameter int CW              = COORD_FRAC_BITS + COEF_MARGIN
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 vld_in,
	input  logic [S_W-1:0]       t_in,
	output ccrs_ctl_t            ctl_out,
	output logic signed [CW-1:0] a0_out [AXES],
	output logic signed [CW-1:0] a1_out [AXES],
	output logic signed [CW-1:0] a2_out [AXES],
	output logic signed [CW-1:0] a3_out [AXES]
);

	localparam int IW = $clog2(N_POINTS);
	localparam int SW = S_W + IW;

	logic signed [CW-1:0] a0_tbl [N_POINTS][AXES];
	logic signed [CW-1:0] a1_tbl [N_POINTS][AXES];
	logic signed [CW-1:0] a2_tbl [N_POINTS][AXES];
	logic signed [CW-1:0] a3_tbl [N_POINTS][AXES];

	logic [SW-1:0] seg;
	logic [IW-1:0] idx;

	logic                 vld_s1;
	logic [S_W-1:0]       s_s1;
	logic signed [CW-1:0] a0_s1 [AXES];
	logic signed [CW-1:0] a1_s1 [AXES];
	logic signed [CW-1:0] a2_s1 [AXES];
	logic signed [CW-1:0] a3_s1 [AXES];

	for (genvar g = 0; g < N_POINTS; g++) begin : g_seg
		for (genvar a = 0; a < AXES; a++) begin : g_axis
			assign a0_tbl[g][a] = CW'(ccrs_coef(N_POINTS, COORD_FRAC_BITS, g, a, COEF_A0));
			assign a1_tbl[g][a] = CW'(ccrs_coef(N_POINTS, COORD_FRAC_BITS, g, a, COEF_A1));
			assign a2_tbl[g][a] = CW'(ccrs_coef(N_POINTS, COORD_FRAC_BITS, g, a, COEF_A2));
			assign a3_tbl[g][a] = CW'(ccrs_coef(N_POINTS, COORD_FRAC_BITS, g, a, COEF_A3));
		end
	end

	assign seg = SW'(t_in) * SW'(N_POINTS);
	assign idx = seg[S_W +: IW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		s_s1 <= seg[S_W-1:0];
		for (int a = 0; a < AXES; a++) begin
			a0_s1[a] <= a0_tbl[idx][a];
			a1_s1[a] <= a1_tbl[idx][a];
			a2_s1[a] <= a2_tbl[idx][a];
			a3_s1[a] <= a3_tbl[idx][a];
		end
	end

	assign ctl_out.vld = vld_s1;
	assign ctl_out.s   = s_s1;
	assign a0_out      = a0_s1;
	assign a1_out      = a1_s1;
	assign a2_out      = a2_s1;
	assign a3_out      = a3_s1;

endmodule

>>> sv/ccrs_horner_step.sv
// One Horner step: multiply by the fraction, round, add the next coefficient.
module ccrs_horner_step import ccrs_pkg::*; #(
	parameter int CW = COORD_FRAC_BITS_DEF + COEF_MARGIN
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ccrs_ctl_t            ctl_in,
	input  logic signed [CW-1:0] acc_in [AXES],
	input  logic signed [CW-1:0] add_in [AXES],
	input  logic signed [CW-1:0] nxt_in [AXES],
	input  logic signed [CW-1:0] far_in [AXES],
	output ccrs_ctl_t            ctl_out,
	output logic signed [CW-1:0] acc_out [AXES],
	output logic signed [CW-1:0] nxt_out [AXES],
	output logic signed [CW-1:0] far_out [AXES]
);

	localparam int PW   = CW + S_W + 1;
	localparam int HALF = 1 << (S_W - 1);

	logic                 vld_s1;
	logic [S_W-1:0]       s_s1;
	logic signed [PW-1:0] prod_s1 [AXES];
	logic signed [CW-1:0] add_s1  [AXES];
	logic signed [CW-1:0] nxt_s1  [AXES];
	logic signed [CW-1:0] far_s1  [AXES];

	logic signed [PW-1:0] rnd [AXES];

	logic                 vld_s2;
	logic [S_W-1:0]       s_s2;
	logic signed [CW-1:0] acc_s2 [AXES];
	logic signed [CW-1:0] nxt_s2 [AXES];
	logic signed [CW-1:0] far_s2 [AXES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= ctl_in.vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		s_s1 <= ctl_in.s;
		for (int a = 0; a < AXES; a++) begin
			prod_s1[a] <= PW'(acc_in[a]) * PW'($signed({1'b0, ctl_in.s}));
			add_s1[a]  <= add_in[a];
			nxt_s1[a]  <= nxt_in[a];
			far_s1[a]  <= far_in[a];
		end
	end

	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			rnd[a] = (prod_s1[a] + PW'(HALF)) >>> S_W;
		end
	end

	always_ff @(posedge clk) begin
		s_s2 <= s_s1;
		for (int a = 0; a < AXES; a++) begin
			acc_s2[a] <= CW'(rnd[a]) + add_s1[a];
			nxt_s2[a] <= nxt_s1[a];
			far_s2[a] <= far_s1[a];
		end
	end

	assign ctl_out.vld = vld_s2;
	assign ctl_out.s   = s_s2;
	assign acc_out     = acc_s2;
	assign nxt_out     = nxt_s2;
	assign far_out     = far_s2;

	a_step_latency: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> $past(ctl_in.vld, 2))
		else $error("step result without an entering beat");

endmodule

>>> sv/closed_catmull_rom_spline_eval.sv
// Top level of the closed uniform Catmull-Rom spline point evaluator.
// A start passes lookup, Horner steps and output register to the valid strobe.
// Throughput: one beat per cycle; busy stays low, the strobe cannot be held off.
// Timing is set by three multiply/round/add pairs, each cut into two registers.
// Reset clears only the valid bits in flight; no clearing pass is needed.
module closed_catmull_rom_spline_eval import ccrs_pkg::*; #(
	parameter int N_POINTS        = N_POINTS_DEF,
	parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [S_W-1:0]          t_phase,
	output logic                    valid,
	output logic signed [OUT_W-1:0] pos_x,
	output logic signed [OUT_W-1:0] pos_y,
	output logic signed [OUT_W-1:0] pos_z
);

	localparam int CW  = COORD_FRAC_BITS + COEF_MARGIN;
	localparam int LAT = 8;

	localparam logic [OUT_W-1:0] P0_X = ccrs_sat(ccrs_coord(0, 0, COORD_FRAC_BITS));
	localparam logic [OUT_W-1:0] P0_Y = ccrs_sat(ccrs_coord(0, 1, COORD_FRAC_BITS));
	localparam logic [OUT_W-1:0] P0_Z = ccrs_sat(ccrs_coord(0, 2, COORD_FRAC_BITS));

	ccrs_ctl_t            ctl_l;
	logic signed [CW-1:0] a0_l [AXES];
	logic signed [CW-1:0] a1_l [AXES];
	logic signed [CW-1:0] a2_l [AXES];
	logic signed [CW-1:0] a3_l [AXES];

	ccrs_ctl_t            ctl_h0;
	logic signed [CW-1:0] acc_h0 [AXES];
	logic signed [CW-1:0] nxt_h0 [AXES];
	logic signed [CW-1:0] far_h0 [AXES];

	ccrs_ctl_t            ctl_h1;
	logic signed [CW-1:0] acc_h1 [AXES];
	logic signed [CW-1:0] nxt_h1 [AXES];

	ccrs_ctl_t            ctl_h2;
	logic signed [CW-1:0] acc_h2 [AXES];

	logic signed [CW-1:0]    half [AXES];
	logic [OUT_W-1:0]        sat  [AXES];

	logic                    vld_s8;
	logic signed [OUT_W-1:0] pos_s8 [AXES];

	assign busy = 1'b0;

	ccrs_coef_lut #(
		.N_POINTS       (N_POINTS),
		.COORD_FRAC_BITS(COORD_FRAC_BITS),
		.CW             (CW)
	) u_lut (
		.clk    (clk),
		.arst_n (arst_n),
		.vld_in (start),
		.t_in   (t_phase),
		.ctl_out(ctl_l),
		.a0_out (a0_l),
		.a1_out (a1_l),
		.a2_out (a2_l),
		.a3_out (a3_l)
	);

	ccrs_horner_step #(.CW(CW)) u_step0 (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_in (ctl_l),
		.acc_in (a3_l),
		.add_in (a2_l),
		.nxt_in (a1_l),
		.far_in (a0_l),
		.ctl_out(ctl_h0),
		.acc_out(acc_h0),
		.nxt_out(nxt_h0),
		.far_out(far_h0)
	);

	ccrs_horner_step #(.CW(CW)) u_step1 (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_in (ctl_h0),
		.acc_in (acc_h0),
		.add_in (nxt_h0),
		.nxt_in (far_h0),
		.far_in (far_h0),
		.ctl_out(ctl_h1),
		.acc_out(acc_h1),
		.nxt_out(nxt_h1),
		.far_out()
	);

	ccrs_horner_step #(.CW(CW)) u_step2 (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_in (ctl_h1),
		.acc_in (acc_h1),
		.add_in (nxt_h1),
		.nxt_in (nxt_h1),
		.far_in (nxt_h1),
		.ctl_out(ctl_h2),
		.acc_out(acc_h2),
		.nxt_out(),
		.far_out()
	);

	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			half[a] = (acc_h2[a] + CW'(1)) >>> 1;
			sat[a]  = ccrs_sat(longint'(half[a]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else begin
			vld_s8 <= ctl_h2.vld;
		end
	end

	always_ff @(posedge clk) begin
		for (int a = 0; a < AXES; a++) begin
			pos_s8[a] <= $signed(sat[a]);
		end
	end

	assign valid = vld_s8;
	assign pos_x = pos_s8[0];
	assign pos_y = pos_s8[1];
	assign pos_z = pos_s8[2];

	a_start_to_valid: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT valid)
		else $error("accepted beat did not come out");

	a_valid_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> $past(start, LAT))
		else $error("result beat with no accepted start");

	a_zero_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && $past(t_phase, LAT) == '0) |->
		(pos_x == P0_X && pos_y == P0_Y && pos_z == P0_Z))
		else $error("zero phase did not return the first control point");

endmodule
